@@ hdl/nearest_mass_limit_strength_macros.svh @@
// Assertion macros shared by the nearest-mass limit strength modules
`ifndef NEAREST_MASS_LIMIT_STRENGTH_MACROS_SVH
`define NEAREST_MASS_LIMIT_STRENGTH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define NMLS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define NMLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

@@ hdl/nmls_pkg.sv @@
// Types and constants of the nearest-mass limit strength block
`timescale 1ns / 1ps

package nmls_pkg;

	localparam int MASS_W    = 24;
	localparam int LIM_W     = 32;
	localparam int XS_W      = 32;
	localparam int BR_W      = 17;
	localparam int IDX_W     = 8;
	localparam int LEN_W     = 9;
	localparam int PROD_W    = XS_W + BR_W;
	localparam int DVD_W     = 48;
	localparam int DVS_W     = 46;
	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = 6;

	// Outlier limit 1e9 held with 16 fraction bits (Q30.16 in 46 bits)
	localparam logic [DVS_W-1:0] OUTLIER_WIDE = 46'd65536000000000;
	localparam logic [31:0]      MAX32        = 32'hFFFF_FFFF;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] ERR_OK         = 2'd0;
	localparam logic [1:0] ERR_EMPTY      = 2'd1;
	localparam logic [1:0] ERR_ZERO_LIMIT = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_wr;
		logic q_start;
		logic issue;
		logic set_empty;
		logic select;
		logic div_step;
		logic finish;
	} nmls_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic len_zero;
		logic issue_last;
		logic zero_lim;
		logic div_last;
	} nmls_sts_t;

endpackage

@@ hdl/nmls_ram.sv @@
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module nmls_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 2560
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/nmls_ctrl.sv @@
// Controller state machine of the nearest-mass limit strength block
`timescale 1ns / 1ps
`include "nearest_mass_limit_strength_macros.svh"

module nmls_ctrl import nmls_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      operation,
	input  nmls_sts_t sts,
	output nmls_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_DRAIN  = 7'b0000100,
		ST_SELECT = 7'b0001000,
		ST_DIV    = 7'b0010000,
		ST_FIN    = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (operation == OP_QUERY) begin
						cmd.q_start = 1'b1;
						state_d     = ST_SCAN;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (sts.len_zero) begin
					cmd.set_empty = 1'b1;
					state_d       = ST_RESULT;
				end else begin
					cmd.issue = 1'b1;
					if (sts.issue_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_SELECT;
			end
			ST_SELECT: begin
				cmd.select = 1'b1;
				state_d    = sts.zero_lim ? ST_RESULT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESULT);

	`NMLS_ASSERT_NEXT(a_query_goes_busy, start && !busy && operation == OP_QUERY, busy)
	`NMLS_ASSERT_NEXT(a_done_single, done, !done)
	`NMLS_ASSERT_NOW(a_done_busy, done, busy)

endmodule

@@ hdl/nmls_dp.sv @@
// Datapath: row tables, nearest-mass scan, product and divider
`timescale 1ns / 1ps
`include "nearest_mass_limit_strength_macros.svh"

module nmls_dp import nmls_pkg::*; #(
	parameter int CHANNELS = 10,
	parameter int ROWS     = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nmls_cmd_t         cmd,
	output nmls_sts_t         sts,
	input  logic [3:0]        channel,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [MASS_W-1:0] mass,
	input  logic [LIM_W-1:0]  limit,
	input  logic              last_entry,
	input  logic [XS_W-1:0]   cross_section,
	input  logic [BR_W-1:0]   branching_ratio,
	output logic [31:0]       strength,
	output logic [31:0]       predicted,
	output logic [IDX_W-1:0]  nearest_index,
	output logic              at_edge,
	output logic [1:0]        error
);

	localparam int ROW_W  = $clog2(ROWS);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH  = CHANNELS * (2 ** ROW_W);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int RAM_W  = MASS_W + LIM_W;

	logic                  ld_ok;
	logic [ADDR_W-1:0]     wr_addr, rd_addr;
	logic [RAM_W-1:0]      ram_rdata;
	logic [LEN_W-1:0]      len_tab_q [CHANNELS];
	logic [LEN_W-1:0]      len_rd;

	logic [3:0]            ch_q;
	logic [MASS_W-1:0]     m_q;
	logic [XS_W-1:0]       xs_q;
	logic [BR_W-1:0]       br_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      rd_idx_q;
	logic                  rvld_s1;
	logic [LEN_W-1:0]      didx_s1;

	logic [PROD_W-1:0]     prod;
	logic [31:0]           pred_q;

	logic [MASS_W-1:0]     r_mass, mass_gap;
	logic [LIM_W-1:0]      r_lim;
	logic [MASS_W-1:0]     best_d_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [LIM_W-1:0]      best_lim_q;
	logic                  edge_c;

	logic [DVD_W-1:0]      dq_q;
	logic [DVS_W-1:0]      rem_q, dvs_q;
	logic [DVS_W:0]        trial;
	logic                  fits;
	logic [CNT_W-1:0]      cnt_q;

	logic [31:0]           str_q;
	logic                  edge_q;
	logic [1:0]            err_q;

	// Row memory: mass and limit side by side, addressed by channel and row
	assign ld_ok   = cmd.load_wr && (32'(channel) < CHANNELS) && (32'(entry_index) < ROWS);
	assign wr_addr = (ADDR_W'(channel) << ROW_W) | ADDR_W'(entry_index);
	assign rd_addr = (ADDR_W'(ch_q) << ROW_W) | ADDR_W'(rd_idx_q);

	nmls_ram #(
		.WIDTH(RAM_W),
		.DEPTH(DEPTH)
	) u_rows (
		.clk  (clk),
		.we   (ld_ok),
		.waddr(wr_addr),
		.wdata({mass, limit}),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Table lengths, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				len_tab_q[i] <= '0;
			end
		end else if (ld_ok && last_entry) begin
			len_tab_q[channel[CH_W-1:0]] <= LEN_W'(entry_index) + LEN_W'(1);
		end
	end

	assign len_rd = (32'(channel) < CHANNELS) ? len_tab_q[channel[CH_W-1:0]] : '0;

	// Scan control: table length, read pointer, read-valid stage, divider count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			rd_idx_q <= '0;
			rvld_s1  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			rvld_s1 <= cmd.issue;
			if (cmd.q_start) begin
				len_q    <= len_rd;
				rd_idx_q <= '0;
			end else if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + LEN_W'(1);
			end
			if (cmd.select) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Capture the query operands
	always_ff @(posedge clk) begin
		didx_s1 <= rd_idx_q;
		if (cmd.q_start) begin
			ch_q <= channel;
			m_q  <= mass;
			xs_q <= cross_section;
			br_q <= branching_ratio;
		end
	end

	// Predicted value, saturated to 32 bits
	assign prod = xs_q * br_q;

	always_ff @(posedge clk) begin
		pred_q <= prod[PROD_W-1] ? MAX32 : prod[PROD_W-2:16];
	end

	// Distance of the row just read from the query mass
	assign r_mass   = ram_rdata[RAM_W-1 -: MASS_W];
	assign r_lim    = ram_rdata[LIM_W-1:0];
	assign mass_gap = (m_q >= r_mass) ? (m_q - r_mass) : (r_mass - m_q);

	assign edge_c = (best_idx_q == '0) || ({1'b0, best_idx_q} == len_q - LEN_W'(1));

	// Divider step: shift in one dividend bit, subtract when it fits
	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Keep the nearest row, run the divider, form the result
	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			best_idx_q <= '0;
			str_q      <= '0;
			edge_q     <= 1'b0;
			err_q      <= ERR_OK;
		end
		if (rvld_s1 && (didx_s1 == '0 || mass_gap < best_d_q)) begin
			best_d_q   <= mass_gap;
			best_idx_q <= didx_s1[IDX_W-1:0];
			best_lim_q <= r_lim;
		end
		if (cmd.set_empty) begin
			err_q <= ERR_EMPTY;
		end
		if (cmd.select) begin
			edge_q <= edge_c;
			if (sts.zero_lim) begin
				str_q <= MAX32;
				err_q <= ERR_ZERO_LIMIT;
			end else begin
				dq_q  <= {pred_q, 16'h0000};
				rem_q <= '0;
				dvs_q <= edge_c ? OUTLIER_WIDE : DVS_W'(best_lim_q);
			end
		end
		if (cmd.div_step) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
		if (cmd.finish) begin
			str_q <= (|dq_q[DVD_W-1:32]) ? MAX32 : dq_q[31:0];
		end
	end

	assign sts.len_zero   = (len_q == '0);
	assign sts.issue_last = (rd_idx_q == len_q - LEN_W'(1));
	assign sts.zero_lim   = !edge_c && (best_lim_q == '0);
	assign sts.div_last   = (cnt_q == '0);

	assign strength      = str_q;
	assign predicted     = pred_q;
	assign nearest_index = best_idx_q;
	assign at_edge       = edge_q;
	assign error         = err_q;

	`NMLS_ASSERT_NOW(a_scan_nonempty, cmd.issue, !sts.len_zero)
	`NMLS_ASSERT_NOW(a_finish_nonzero, cmd.finish, !sts.len_zero && !sts.zero_lim)

endmodule

@@ hdl/nearest_mass_limit_strength.sv @@
// Top level of the nearest-mass limit strength block
`timescale 1ns / 1ps

// Command channel: a word is taken when start is high and busy is low.
// operation selects a row load or a query; the other fields ride alongside.
// A load writes one (mass, limit) row of a channel table in the cycle it is
// taken and leaves busy low, so loads can follow back to back.
// A query raises busy, scans the channel table one row a cycle through the
// row memory's single read port, then runs a 48-step restoring divider.
// A query on an empty table skips the scan, and one whose limit used is zero
// skips the divider; busy drops the cycle after the result.
// Result channel: done is high for exactly one cycle with strength,
// predicted, nearest_index, at_edge and error; the receiver cannot stall it
// and must take the word in that cycle.
// Reset clears every table length to zero; the row memory is not cleared
// and needs no clearing pass, rows are valid once written.
module nearest_mass_limit_strength import nmls_pkg::*; #(
	parameter int CHANNELS = 10,
	parameter int ROWS     = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [3:0]        channel,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [MASS_W-1:0] mass,
	input  logic [LIM_W-1:0]  limit,
	input  logic              last_entry,
	input  logic [XS_W-1:0]   cross_section,
	input  logic [BR_W-1:0]   branching_ratio,
	output logic              done,
	output logic [31:0]       strength,
	output logic [31:0]       predicted,
	output logic [IDX_W-1:0]  nearest_index,
	output logic              at_edge,
	output logic [1:0]        error
);

	nmls_cmd_t cmd;
	nmls_sts_t sts;

	// Sequence loads and queries
	nmls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// Tables, scan and arithmetic
	nmls_dp #(
		.CHANNELS(CHANNELS),
		.ROWS    (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.channel        (channel),
		.entry_index    (entry_index),
		.mass           (mass),
		.limit          (limit),
		.last_entry     (last_entry),
		.cross_section  (cross_section),
		.branching_ratio(branching_ratio),
		.strength       (strength),
		.predicted      (predicted),
		.nearest_index  (nearest_index),
		.at_edge        (at_edge),
		.error          (error)
	);

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the nearest-mass limit strength block
`timescale 1ns / 1ps

module tb_top import nmls_pkg::*; ();

	localparam int NUM_CH        = 10;
	localparam int NUM_ROWS      = 256;
	localparam int RANDOM_WORDS  = 1000;
	localparam int CALM_TAIL     = 100;
	localparam int DRAIN_CYCLES  = 400;
	localparam int WATCHDOG_MAX  = 4000;

	// One command word as the block takes it
	typedef struct packed {
		logic                 operation;
		logic [3:0]           channel;
		logic [IDX_W-1:0]     entry_index;
		logic [MASS_W-1:0]    mass;
		logic [LIM_W-1:0]     limit;
		logic                 last_entry;
		logic [XS_W-1:0]      cross_section;
		logic [BR_W-1:0]      branching_ratio;
	} cmd_word_t;

	// One result word
	typedef struct packed {
		logic [31:0]          strength;
		logic [31:0]          predicted;
		logic [IDX_W-1:0]     nearest_index;
		logic                 at_edge;
		logic [1:0]           error;
	} ratio_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 operation = OP_LOAD;
	logic [3:0]           channel = '0;
	logic [IDX_W-1:0]     entry_index = '0;
	logic [MASS_W-1:0]    mass = '0;
	logic [LIM_W-1:0]     limit = '0;
	logic                 last_entry = 1'b0;
	logic [XS_W-1:0]      cross_section = '0;
	logic [BR_W-1:0]      branching_ratio = '0;
	logic                 done;
	logic [31:0]          strength;
	logic [31:0]          predicted;
	logic [IDX_W-1:0]     nearest_index;
	logic                 at_edge;
	logic [1:0]           error;

	// Words waiting to be sent and results owed by the block
	cmd_word_t            cmd_backlog[$];
	ratio_word_t          strength_due[$];
	int                   fail_count = 0;

	// Table contents as the block should hold them
	logic [MASS_W-1:0]    held_mass[NUM_CH][NUM_ROWS];
	logic [LIM_W-1:0]     held_limit[NUM_CH][NUM_ROWS];
	int                   held_len[NUM_CH];

	// Table contents as planned while the stimulus is laid out
	bit                   plan_written[NUM_CH][NUM_ROWS];
	logic [MASS_W-1:0]    plan_mass[NUM_CH][NUM_ROWS];
	int                   plan_len[NUM_CH];

	// Driver state
	cmd_word_t            on_bus;
	logic                 took;
	logic                 next_start;
	int                   idle_left = 0;
	bit                   idle_mode = 1'b1;
	int                   quiet_cycles = 0;

	nearest_mass_limit_strength #(
		.CHANNELS(NUM_CH),
		.ROWS(NUM_ROWS)
	) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one accepted word to the held tables; queue the ratio a query owes
	task automatic rate_word(input cmd_word_t w);
		ratio_word_t          r;
		logic [PROD_W-1:0]    prod;
		logic [32:0]          scaled;
		logic [63:0]          divisor;
		logic [63:0]          quo;
		logic [MASS_W-1:0]    rm;
		logic [MASS_W-1:0]    gap;
		logic [MASS_W-1:0]    best_dist;
		int                   n;
		int                   best;
		int                   ch;
		ch = int'(w.channel);
		if (w.operation == OP_LOAD) begin
			if (ch < NUM_CH) begin
				held_mass[ch][w.entry_index] = w.mass;
				held_limit[ch][w.entry_index] = w.limit;
				if (w.last_entry)
					held_len[ch] = int'(w.entry_index) + 1;
			end
		end else begin
			prod = PROD_W'(w.cross_section) * PROD_W'(w.branching_ratio);
			scaled = prod[PROD_W-1:16];
			r = '0;
			r.predicted = (scaled > 33'(MAX32)) ? MAX32 : scaled[31:0];
			r.error = ERR_OK;
			n = (ch < NUM_CH) ? held_len[ch] : 0;
			if (n == 0) begin
				r.error = ERR_EMPTY;
			end else begin
				best = 0;
				best_dist = '0;
				// scan rows, first one wins a tie
				for (int i = 0; i < n; i++) begin
					rm = held_mass[ch][i];
					gap = (w.mass >= rm) ? w.mass - rm : rm - w.mass;
					if (i == 0 || gap < best_dist) begin
						best_dist = gap;
						best = i;
					end
				end
				r.nearest_index = best[IDX_W-1:0];
				if (best == 0 || best == n - 1) begin
					r.at_edge = 1'b1;
					divisor = 64'(OUTLIER_WIDE);
				end else begin
					divisor = 64'(held_limit[ch][best]);
				end
				if (divisor == 0) begin
					r.strength = MAX32;
					r.error = ERR_ZERO_LIMIT;
				end else begin
					quo = {16'b0, r.predicted, 16'b0} / divisor;
					r.strength = (quo > 64'(MAX32)) ? MAX32 : quo[31:0];
				end
			end
			strength_due.push_back(r);
		end
	endtask

	function automatic logic [31:0] rand_wide();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return MAX32;
			2: return 32'($urandom_range(0, 255));
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [MASS_W-1:0] rand_mass();
		logic [31:0] raw;
		raw = $urandom >> $urandom_range(8, 31);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return raw[MASS_W-1:0];
		endcase
	endfunction

	function automatic logic [BR_W-1:0] rand_ratio();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return BR_W'(65536);
			2: return BR_W'($urandom_range(65537, 131071));
			default: return BR_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// Queue a row load; track what it does to the planned table
	task automatic queue_load(input int ch, input int idx, input logic [MASS_W-1:0] m,
			input logic [LIM_W-1:0] lim, input bit last);
		cmd_word_t w;
		w.operation = OP_LOAD;
		w.channel = ch[3:0];
		w.entry_index = idx[IDX_W-1:0];
		w.mass = m;
		w.limit = lim;
		w.last_entry = last;
		w.cross_section = $urandom;
		w.branching_ratio = BR_W'($urandom);
		cmd_backlog.push_back(w);
		if (ch < NUM_CH) begin
			plan_written[ch][idx] = 1'b1;
			plan_mass[ch][idx] = m;
			if (last)
				plan_len[ch] = idx + 1;
		end
	endtask

	// Queue a query; fields unused by a query carry noise
	task automatic queue_query(input int ch, input logic [MASS_W-1:0] m,
			input logic [XS_W-1:0] xs, input logic [BR_W-1:0] br);
		cmd_word_t w;
		w.operation = OP_QUERY;
		w.channel = ch[3:0];
		w.entry_index = IDX_W'($urandom);
		w.mass = m;
		w.limit = $urandom;
		w.last_entry = 1'($urandom);
		w.cross_section = xs;
		w.branching_ratio = br;
		cmd_backlog.push_back(w);
	endtask

	// Load rows 0..n-1 of a channel in order, marking the last one
	task automatic lay_table(input int ch, input int n);
		int                style;
		int                step;
		int unsigned       m;
		logic [MASS_W-1:0] row_m;
		logic [LIM_W-1:0]  lim;
		style = $urandom_range(0, 2);
		step = 1 << $urandom_range(0, 16);
		m = $urandom_range(0, 4096);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: begin
					m = m + $urandom_range(0, step);
					if (m > 24'hFF_FFFF)
						m = 24'hFF_FFFF;
					row_m = m[MASS_W-1:0];
				end
				1: row_m = rand_mass();
				default: row_m = MASS_W'($urandom_range(0, 3) * 1000);
			endcase
			lim = ($urandom_range(0, 7) == 0) ? '0 : rand_wide();
			queue_load(ch, i, row_m, lim, i == n - 1);
		end
	endtask

	// A table is safe to query when every row below its length was written
	function automatic bit table_sound(input int ch);
		if (ch >= NUM_CH)
			return 1'b1;
		for (int i = 0; i < plan_len[ch]; i++)
			if (!plan_written[ch][i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Pick a query mass on, near or midway between planned rows, or at random
	function automatic logic [MASS_W-1:0] aim_mass(input int ch);
		int          r;
		int          m;
		logic [24:0] sum;
		if (ch >= NUM_CH || plan_len[ch] == 0 || $urandom_range(0, 4) == 0)
			return rand_mass();
		r = $urandom_range(0, plan_len[ch] - 1);
		case ($urandom_range(0, 2))
			0: return plan_mass[ch][r];
			1: begin
				m = int'(plan_mass[ch][r]) + int'($urandom_range(0, 600)) - 300;
				if (m < 0)
					m = 0;
				if (m > 24'hFF_FFFF)
					m = 24'hFF_FFFF;
				return m[MASS_W-1:0];
			end
			default: begin
				if (r + 1 >= plan_len[ch])
					return plan_mass[ch][r];
				sum = plan_mass[ch][r] + plan_mass[ch][r + 1];
				return sum[24:1];
			end
		endcase
	endfunction

	task automatic lay_directed();
		// empty table, out-of-range channel, saturated product
		queue_query(0, '0, '0, '0);
		queue_query(15, '1, MAX32, '1);
		queue_load(12, 0, 24'h000100, 32'd5, 1'b1);
		queue_query(12, 24'h000100, 32'h0001_0000, BR_W'(65536));
		// single-row table: row 0 is an edge
		queue_load(1, 0, 24'h000100, 32'd5, 1'b1);
		queue_query(1, '1, MAX32, BR_W'(65536));
		// three rows: middle limit of one overflows the quotient
		queue_load(2, 0, 24'h000000, MAX32, 1'b0);
		queue_load(2, 1, 24'h001000, 32'd1, 1'b0);
		queue_load(2, 2, 24'hFF_FFFF, MAX32, 1'b1);
		queue_query(2, 24'h001000, 32'h0001_0000, BR_W'(65536));
		queue_query(2, 24'h000000, MAX32, '1);
		queue_query(2, 24'hFF_FFFF, 32'h1234_5678, BR_W'(40000));
		// five rows: zero limit, ties between middle rows
		queue_load(3, 0, 24'h000010, 32'd7, 1'b0);
		queue_load(3, 1, 24'h000100, 32'd0, 1'b0);
		queue_load(3, 2, 24'h000200, 32'h0002_0000, 1'b0);
		queue_load(3, 3, 24'h000300, 32'd9, 1'b0);
		queue_load(3, 4, 24'hFF_FFFF, 32'd3, 1'b1);
		queue_query(3, 24'h000100, '0, '0);
		queue_query(3, 24'h000180, 32'h0000_8000, BR_W'(32768));
		queue_query(3, 24'h000280, 32'h0003_0000, BR_W'(65536));
		queue_query(3, 24'h000200, MAX32, '1);
	endtask

	task automatic lay_random();
		int  ch;
		int  idx;
		int  pick;
		bit  wide_done;
		int  target;
		wide_done = 1'b0;
		target = cmd_backlog.size() + RANDOM_WORDS;
		while (cmd_backlog.size() < target) begin
			pick = $urandom_range(0, 99);
			if (!wide_done && cmd_backlog.size() > target / 2) begin
				// one full table, then a run of queries on it
				wide_done = 1'b1;
				ch = $urandom_range(0, NUM_CH - 1);
				lay_table(ch, NUM_ROWS);
				repeat (20)
					queue_query(ch, aim_mass(ch), rand_wide(), rand_ratio());
			end else if (pick < 10) begin
				ch = $urandom_range(0, NUM_CH - 1);
				lay_table(ch, ($urandom_range(0, 4) == 0) ?
					$urandom_range(13, 40) : $urandom_range(1, 12));
			end else if (pick < 20) begin
				// stray load, may shorten or lengthen a table
				ch = $urandom_range(0, 15);
				if (ch < NUM_CH && $urandom_range(0, 1))
					idx = $urandom_range(0, (plan_len[ch] + 3 > 255) ? 255 : plan_len[ch] + 3);
				else
					idx = $urandom_range(0, 255);
				queue_load(ch, idx, rand_mass(), rand_wide(), $urandom_range(0, 4) == 0);
			end else begin
				ch = (pick < 94) ? $urandom_range(0, NUM_CH - 1) : $urandom_range(NUM_CH, 15);
				if (!table_sound(ch))
					ch = $urandom_range(NUM_CH, 15);
				queue_query(ch, aim_mass(ch), rand_wide(), rand_ratio());
			end
		end
	endtask

	// Drive words from the backlog; hold a word until busy lets it in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			idle_left <= 0;
		end else begin
			took = start && !busy;
			if (took)
				rate_word(on_bus);
			if (start && !took) begin
				next_start = 1'b1;
			end else if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				next_start = 1'b0;
			end else if (cmd_backlog.size() == 0) begin
				next_start = 1'b0;
			end else if (cmd_backlog.size() > CALM_TAIL && idle_mode &&
					$urandom_range(0, 3) == 0) begin
				idle_left <= $urandom_range(0, 13);
				next_start = 1'b0;
			end else begin
				on_bus = cmd_backlog.pop_front();
				operation <= on_bus.operation;
				channel <= on_bus.channel;
				entry_index <= on_bus.entry_index;
				mass <= on_bus.mass;
				limit <= on_bus.limit;
				last_entry <= on_bus.last_entry;
				cross_section <= on_bus.cross_section;
				branching_ratio <= on_bus.branching_ratio;
				next_start = 1'b1;
			end
			if ($urandom_range(0, 49) == 0)
				idle_mode <= !idle_mode;
			start <= next_start;
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare each result word with the oldest owed one
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (strength_due.size() == 0) begin
				$error("result word with none owed: strength %0h", strength);
				fail_count++;
			end else begin
				check_field("strength", strength_due[0].strength, strength);
				check_field("predicted", strength_due[0].predicted, predicted);
				check_field("nearest_index", 32'(strength_due[0].nearest_index),
					32'(nearest_index));
				check_field("at_edge", 32'(strength_due[0].at_edge), 32'(at_edge));
				check_field("error", 32'(strength_due[0].error), 32'(error));
				void'(strength_due.pop_front());
			end
		end
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int c = 0; c < NUM_CH; c++) begin
			held_len[c] = 0;
			plan_len[c] = 0;
		end
		lay_directed();
		lay_random();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// wait for the backlog to drain and every owed result to arrive
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || start || busy || strength_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && strength_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
